// ===== hdl/pool_pkg.sv =====
// Shared types and constants for the 2D pooling block.
package pool_pkg;

  localparam logic [1:0] MODE_MAX = 2'd0;
  localparam logic [1:0] MODE_AVG = 2'd1;
  localparam logic [1:0] MODE_RMS = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_POOL  = 1'b1;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_STRIDE_R = 3'd1;
  localparam logic [2:0] REG_STRIDE_C = 3'd2;
  localparam logic [2:0] REG_PAD_R    = 3'd3;
  localparam logic [2:0] REG_PAD_C    = 3'd4;
  localparam logic [2:0] REG_WIN_R    = 3'd5;
  localparam logic [2:0] REG_WIN_C    = 3'd6;

  // One classified command passed from the front part to the back part.
  typedef struct packed {
    logic        is_pool;
    logic        empty;
    logic [1:0]  mode;
    logic [8:0]  row_start;
    logic [8:0]  row_end;
    logic [8:0]  col_start;
    logic [8:0]  col_end;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [3:0]  chan;
    logic [15:0] sample;
  } pool_cmd_t;

endpackage

// ===== hdl/pool_front.sv =====
// Front part: holds the configuration and turns an input word into a command.
module pool_front
  import pool_pkg::*;
#(
  parameter int MAP_ROWS   = 16,
  parameter int MAP_COLS   = 16,
  parameter int CHANNELS   = 16,
  parameter int MAX_WINDOW = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        opcode,
  input  logic [3:0]  row,
  input  logic [3:0]  col,
  input  logic [3:0]  chan,
  input  logic [15:0] sample,
  output pool_cmd_t   cmd
);

  logic [1:0] pool_mode;
  logic [3:0] stride_rows, stride_cols, window_rows, window_cols;
  logic [2:0] pad_rows, pad_cols;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode   <= MODE_MAX;
      stride_rows <= 4'd1;
      stride_cols <= 4'd1;
      pad_rows    <= 3'd0;
      pad_cols    <= 3'd0;
      window_rows <= 4'd2;
      window_cols <= 4'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:     pool_mode   <= cfg_data[1:0];
        REG_STRIDE_R: stride_rows <= cfg_data[3:0];
        REG_STRIDE_C: stride_cols <= cfg_data[3:0];
        REG_PAD_R:    pad_rows    <= cfg_data[2:0];
        REG_PAD_C:    pad_cols    <= cfg_data[2:0];
        REG_WIN_R:    window_rows <= cfg_data[3:0];
        REG_WIN_C:    window_cols <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Signed 10-bit arithmetic covers origin -7..225 plus a window of up to MAX_WINDOW.
  logic signed [9:0] r_org, c_org, r_e, c_e, r_s, c_s, r_en, c_en;
  logic [4:0] r_w, c_w;

  always_comb begin
    r_w = ({1'b0, window_rows} > 5'(MAX_WINDOW)) ? 5'(MAX_WINDOW) : {1'b0, window_rows};
    c_w = ({1'b0, window_cols} > 5'(MAX_WINDOW)) ? 5'(MAX_WINDOW) : {1'b0, window_cols};
    r_org = $signed({2'b00, 8'(row) * 8'(stride_rows)}) - $signed({7'd0, pad_rows});
    c_org = $signed({2'b00, 8'(col) * 8'(stride_cols)}) - $signed({7'd0, pad_cols});
    r_e = r_org + $signed({5'd0, r_w});
    c_e = c_org + $signed({5'd0, c_w});
    r_s = r_org[9] ? 10'sd0 : r_org;
    c_s = c_org[9] ? 10'sd0 : c_org;
    r_en = (r_e > $signed(10'(MAP_ROWS))) ? $signed(10'(MAP_ROWS)) : r_e;
    c_en = (c_e > $signed(10'(MAP_COLS))) ? $signed(10'(MAP_COLS)) : c_e;
  end

  always_comb begin
    cmd.is_pool   = (opcode == OP_POOL);
    cmd.empty     = (r_en <= r_s) || (c_en <= c_s) || (32'(chan) >= CHANNELS);
    cmd.mode      = pool_mode;
    cmd.row_start = r_s[8:0];
    cmd.row_end   = r_en[8:0];
    cmd.col_start = c_s[8:0];
    cmd.col_end   = c_en[8:0];
    cmd.row       = row;
    cmd.col       = col;
    cmd.chan      = chan;
    cmd.sample    = sample;
  end

  // in_valid only qualifies the queue push in the top level.
  logic unused_ok;
  assign unused_ok = in_valid | (|cfg_data[31:4]);

endmodule

// ===== hdl/pool_back.sv =====
// Back part: owns the feature map, walks a window and runs divide and root.
module pool_back
  import pool_pkg::*;
#(
  parameter int MAP_ROWS = 16,
  parameter int MAP_COLS = 16,
  parameter int CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pool_cmd_t          cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [16:0] pooled,
  output logic               empty_window
);

  localparam int DEPTH = MAP_ROWS * MAP_COLS * CHANNELS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_ACC, S_DIV, S_SQRT, S_OUT} state_t;

  state_t state;
  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data;
  logic [AW-1:0] rd_addr;
  pool_cmd_t cur;
  logic [8:0] r, c;
  logic last_addr;
  logic signed [41:0] sum;
  logic signed [16:0] best;
  logic [7:0] count;
  // Restoring divider on magnitudes, then a bit-pair square root.
  logic [41:0] quo, rem_q;
  logic [5:0] step;
  logic neg;
  logic [41:0] sq_v, sq_res, sq_bit;

  function automatic logic [AW-1:0] addr_of(logic [8:0] rr, logic [8:0] cc,
                                            logic [3:0] ch);
    logic [31:0] a;
    a = (32'(rr) * MAP_COLS + 32'(cc)) * CHANNELS + 32'(ch);
    return a[AW-1:0];
  endfunction

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && !cmd.is_pool &&
        32'(cmd.row) < MAP_ROWS && 32'(cmd.col) < MAP_COLS &&
        32'(cmd.chan) < CHANNELS)
      mem[addr_of({5'd0, cmd.row}, {5'd0, cmd.col}, cmd.chan)] <= cmd.sample;
    rd_data <= mem[rd_addr];
  end

  assign rd_addr = addr_of(r, c, cur.chan);

  logic signed [31:0] sq;
  logic [42:0] trial;
  logic [41:0] sq_sum;
  always_comb begin
    sq = $signed(rd_data) * $signed(rd_data);
    trial = {rem_q, quo[41]} - {35'd0, count};
    sq_sum = sq_res + sq_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.is_pool) begin
            cur <= cmd;
            r <= cmd.row_start;
            c <= cmd.col_start;
            sum <= '0;
            best <= -17'sd65536;
            count <= '0;
            if (cmd.empty) begin
              pooled <= '0;
              empty_window <= 1'b1;
              res_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          last_addr <= (c + 9'd1 == cur.col_end) && (r + 9'd1 == cur.row_end);
          if (c + 9'd1 == cur.col_end) begin
            c <= cur.col_start;
            r <= r + 9'd1;
          end else begin
            c <= c + 9'd1;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          count <= count + 8'd1;
          if ($signed({rd_data[15], rd_data}) > best) best <= $signed({rd_data[15], rd_data});
          if (cur.mode == MODE_RMS) sum <= sum + 42'($unsigned(sq));
          else sum <= sum + 42'($signed(rd_data));
          if (last_addr) begin
            state <= S_DIV;
            step <= 6'd0;
            rem_q <= '0;
          end else begin
            state <= S_READ;
          end
        end
        S_DIV: begin
          if (step == 6'd0) begin
            neg <= sum[41];
            quo <= sum[41] ? 42'(-sum) : sum;
            rem_q <= '0;
            if (cur.mode != MODE_AVG && cur.mode != MODE_RMS) begin
              pooled <= best;
              empty_window <= 1'b0;
              res_valid <= 1'b1;
              state <= S_OUT;
            end
            step <= 6'd1;
          end else if (step <= 6'd42) begin
            if (!trial[42]) begin
              rem_q <= trial[41:0];
              quo <= {quo[40:0], 1'b1};
            end else begin
              rem_q <= {rem_q[40:0], quo[41]};
              quo <= {quo[40:0], 1'b0};
            end
            step <= step + 6'd1;
          end else begin
            if (cur.mode == MODE_AVG) begin
              pooled <= neg ? -quo[16:0] : quo[16:0];
              empty_window <= 1'b0;
              res_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              sq_v <= quo;
              sq_res <= '0;
              sq_bit <= 42'd1 << 40;
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (sq_bit == '0) begin
            pooled <= sq_res[16:0];
            empty_window <= 1'b0;
            res_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            if (sq_v >= sq_sum) begin
              sq_v <= sq_v - sq_sum;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/pool_queue.sv =====
// Short queue of commands between the front and back parts.
module pool_queue
  import pool_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  pool_cmd_t din,
  output logic      valid,
  input  logic      take,
  output pool_cmd_t dout
);

  pool_cmd_t slots [2];
  logic      wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (take && valid) rp <= ~rp;
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((take && valid) ? 1 : 0);
    end
  end

endmodule

// ===== hdl/pooling_2d_max_avg_l2.sv =====
// Top level of the 2D max / average / root-mean-square pooling block.
// A write word passes through the command queue and is then written into the feature map.
// A pool word reads and accumulates each window element in turn (at most MAX_WINDOW x MAX_WINDOW),
// then runs the divider for average and root-mean-square and the square root for root-mean-square.
// Reset (rst, synchronous) restores the configuration defaults and empties the command queue;
// the feature map is not cleared and must be written before it is read.
module pooling_2d_max_avg_l2
  import pool_pkg::*;
#(
  parameter int MAP_ROWS   = 16,
  parameter int MAP_COLS   = 16,
  parameter int CHANNELS   = 16,
  parameter int MAX_WINDOW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic [3:0]         chan,
  input  logic signed [15:0] sample,
  output logic               empty,
  input  logic               pop,
  output logic signed [16:0] pooled,
  output logic               empty_window
);

  pool_cmd_t fcmd, qcmd;
  logic q_valid, q_take, res_valid;

  pool_front #(.MAP_ROWS(MAP_ROWS), .MAP_COLS(MAP_COLS), .CHANNELS(CHANNELS),
               .MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid(push), .opcode, .row, .col, .chan, .sample, .cmd(fcmd)
  );

  pool_queue u_queue (
    .clk, .rst, .push, .full, .din(fcmd),
    .valid(q_valid), .take(q_take), .dout(qcmd)
  );

  pool_back #(.MAP_ROWS(MAP_ROWS), .MAP_COLS(MAP_COLS), .CHANNELS(CHANNELS)) u_back (
    .clk, .rst, .cmd_valid(q_valid), .cmd_ready(q_take), .cmd(qcmd),
    .res_valid, .res_ready(pop), .pooled, .empty_window
  );

  assign empty = ~res_valid;

endmodule
